@@ src/sdr_pkg.sv @@
package sdr_pkg;

  localparam int VALUE_W          = 32;
  localparam int TOTAL_W          = 9;
  localparam int TABLE_DEPTH_DEF  = 256;

  // one finished result as handed from the scan engine to the output stage
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      kept;
    logic [TOTAL_W-1:0]        total;
    logic                      done;
    logic                      ovf;
  } res_t;

endpackage

@@ src/stream_duplicate_remover.sv @@
// order-preserving duplicate removal over sets of signed 32-bit values
//
// input channel: sample_valid / sample_ready carry sample_value and ends_set;
// a transaction is taken when both are high. ends_set marks the last element
// of a set, after which the distinct table is logically empty again.
// output channel: result_valid / result_ready carry one result per input
// transaction: echoed_value, kept, distinct_total, set_done and overflow.
//
// timing: each transaction walks the stored entries of the current set, one
// table read per cycle from a single-port-read memory with registered data.
// a new value (or overflow) is decided once every stored entry of the set has
// been read, and a repeat ends the walk at the entry where it is found. the
// next ready and the result appear together; no new transaction is taken
// while one is still being scanned or waits to commit.
//
// reset clears the count and the control state only; table contents are
// never read before being written, so no clearing pass is needed.
// the result sits in an output register: while the receiver stalls, the next
// transaction is still accepted and scanned, and only its final commit waits
// until the output register frees up.
module stream_duplicate_remover
  import sdr_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      sample_valid,
  output logic                      sample_ready,
  input  logic signed [VALUE_W-1:0] sample_value,
  input  logic                      ends_set,
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic signed [VALUE_W-1:0] echoed_value,
  output logic                      kept,
  output logic [TOTAL_W-1:0]        distinct_total,
  output logic                      set_done,
  output logic                      overflow
);

  localparam int AW = $clog2(TABLE_DEPTH);

  // scan engine to output stage
  logic res_valid;
  logic res_ready;
  res_t res;

  // table memory port wiring
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [VALUE_W-1:0] mem_rdata;

  // output register, holds one finished result
  res_t out_reg;

  sdr_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sdr_scan #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_value (sample_value),
    .ends_set     (ends_set),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  // the register may take a new result when empty or being drained this cycle
  assign res_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_ready) begin
      result_valid <= res_valid;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_reg <= res;
    end
  end

  assign echoed_value   = out_reg.value;
  assign kept           = out_reg.kept;
  assign distinct_total = out_reg.total;
  assign set_done       = out_reg.done;
  assign overflow       = out_reg.ovf;

endmodule

@@ src/sdr_ram.sv @@
module sdr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/sdr_scan.sv @@
module sdr_scan
  import sdr_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // input transaction
  input  logic                           sample_valid,
  output logic                           sample_ready,
  input  logic signed [VALUE_W-1:0]      sample_value,
  input  logic                           ends_set,
  // finished result toward the output stage
  output logic                           res_valid,
  input  logic                           res_ready,
  output res_t                           res,
  // table memory
  output logic                           mem_we,
  output logic [$clog2(TABLE_DEPTH)-1:0] mem_waddr,
  output logic [VALUE_W-1:0]             mem_wdata,
  output logic                           mem_re,
  output logic [$clog2(TABLE_DEPTH)-1:0] mem_raddr,
  input  logic [VALUE_W-1:0]             mem_rdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    DECIDE
  } state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [CW-1:0]   iss;
  logic            pv;
  logic            hit;
  logic [VALUE_W-1:0] val;
  logic            last;

  logic            store;
  logic [CW-1:0]   count_after;
  logic [CW+TOTAL_W-1:0] total_wide;

  assign sample_ready = (state == IDLE);

  // one table read per cycle while entries remain
  assign mem_re    = (state == SCAN) && (iss < count);
  assign mem_raddr = iss[AW-1:0];

  assign store       = !hit && (count < CW'(TABLE_DEPTH));
  assign count_after = store ? count + CW'(1) : count;
  assign total_wide  = (CW + TOTAL_W)'(count_after);

  assign mem_we    = (state == DECIDE) && res_ready && store;
  assign mem_waddr = count[AW-1:0];
  assign mem_wdata = val;

  assign res_valid = (state == DECIDE);
  assign res.value = $signed(val);
  assign res.kept  = store;
  assign res.total = total_wide[TOTAL_W-1:0];
  assign res.done  = last;
  assign res.ovf   = !hit && !store;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
      iss   <= '0;
      pv    <= 1'b0;
      hit   <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (sample_valid) begin
            val   <= sample_value;
            last  <= ends_set;
            iss   <= '0;
            pv    <= 1'b0;
            hit   <= 1'b0;
            state <= SCAN;
          end
        end
        SCAN: begin
          // read data of the previous issue is compared this cycle
          if (pv && (mem_rdata == val)) begin
            hit   <= 1'b1;
            state <= DECIDE;
          end else if (!pv && (iss == count)) begin
            state <= DECIDE;
          end
          if (iss < count) begin
            iss <= iss + CW'(1);
            pv  <= 1'b1;
          end else begin
            pv  <= 1'b0;
          end
        end
        DECIDE: begin
          if (res_ready) begin
            count <= last ? '0 : count_after;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

@@ test/tb_stream_duplicate_remover.sv @@
`timescale 1ns / 100ps

module tb_stream_duplicate_remover;
  import sdr_pkg::*;

  localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;

  localparam logic signed [VALUE_W-1:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] MOST_POS = 32'sh7FFF_FFFF;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } sample_t;

  logic                      clk            = 1'b0;
  logic                      rst            = 1'b1;
  logic                      sample_valid   = 1'b0;
  logic                      sample_ready;
  logic signed [VALUE_W-1:0] sample_value   = '0;
  logic                      ends_set       = 1'b0;
  logic                      result_valid;
  logic                      result_ready   = 1'b0;
  logic signed [VALUE_W-1:0] echoed_value;
  logic                      kept;
  logic [TOTAL_W-1:0]        distinct_total;
  logic                      set_done;
  logic                      overflow;

  // stimulus waiting to be driven, and results the block still owes us
  sample_t pending_samples[$];
  res_t    expected_results[$];
  int      mismatches = 0;
  int      queued     = 0;

  // shadow of the distinct table for the set in progress
  logic signed [VALUE_W-1:0] set_values[TABLE_DEPTH];
  int unsigned               set_count = 0;

  // sender burst / gap bookkeeping and receiver stall pattern
  int gap_left   = 0;
  int burst_left = 1;
  int hold_left  = 0;

  stream_duplicate_remover #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .sample_valid  (sample_valid),
    .sample_ready  (sample_ready),
    .sample_value  (sample_value),
    .ends_set      (ends_set),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .echoed_value  (echoed_value),
    .kept          (kept),
    .distinct_total(distinct_total),
    .set_done      (set_done),
    .overflow      (overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // work out the result of one accepted transaction and advance the shadow table
  function automatic void predict_dedup(input logic signed [VALUE_W-1:0] v,
                                        input logic last);
    res_t want;
    bit   seen;
    seen = 1'b0;
    for (int i = 0; i < set_count; i++)
      if (set_values[i] == v) seen = 1'b1;
    want.value = v;
    want.kept  = 1'b0;
    want.ovf   = 1'b0;
    if (!seen) begin
      if (set_count < TABLE_DEPTH) begin
        set_values[set_count] = v;
        set_count++;
        want.kept = 1'b1;
      end else begin
        // table full: new value is dropped and flagged
        want.ovf = 1'b1;
      end
    end
    // only the low bits of the count are visible on the port
    want.total = set_count[TOTAL_W-1:0];
    want.done  = last;
    expected_results.push_back(want);
    if (last) set_count = 0;
  endfunction

  task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                             input logic [VALUE_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic add_sample(input logic signed [VALUE_W-1:0] v, input logic last);
    sample_t s;
    s.value = v;
    s.last  = last;
    pending_samples.push_back(s);
    queued++;
  endtask

  // short set with heavy reuse of a small pool, plain random values and extremes
  task automatic small_random_set();
    int                        len;
    logic signed [VALUE_W-1:0] base;
    logic signed [VALUE_W-1:0] v;
    len  = $urandom_range(1, 24);
    base = $urandom;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 3))
        0, 1: v = base + $urandom_range(0, 7);
        2:    v = $urandom;
        default: begin
          case ($urandom_range(0, 3))
            0:       v = MOST_NEG;
            1:       v = MOST_POS;
            2:       v = '0;
            default: v = -1;
          endcase
        end
      endcase
      add_sample(v, i == len - 1);
    end
  endtask

  // fill the table completely, then push new values (overflow) and repeats
  task automatic full_table_set();
    logic signed [VALUE_W-1:0] stored[$];
    logic signed [VALUE_W-1:0] v;
    bit                        clash;
    int                        tail;
    while (stored.size() < TABLE_DEPTH) begin
      v     = $urandom;
      clash = 1'b0;
      foreach (stored[i])
        if (stored[i] == v) clash = 1'b1;
      if (!clash) begin
        stored.push_back(v);
        add_sample(v, 1'b0);
      end
      // sprinkle repeats while the table is still filling
      if (stored.size() > 0 && $urandom_range(0, 7) == 0)
        add_sample(stored[$urandom_range(0, stored.size() - 1)], 1'b0);
    end
    tail = $urandom_range(4, 12);
    for (int i = 0; i < tail; i++) begin
      // new values are near-certainly absent; repeats must stay plain duplicates
      if ($urandom_range(0, 1) == 0)
        v = $urandom;
      else
        v = stored[$urandom_range(0, stored.size() - 1)];
      add_sample(v, i == tail - 1);
    end
  endtask

  // driver: bursts of transactions separated by random gaps
  always @(posedge clk) begin
    sample_t nxt;
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && sample_ready)
        predict_dedup(sample_value, ends_set);
      if (!sample_valid || sample_ready) begin
        if (gap_left > 0 || pending_samples.size() == 0) begin
          if (gap_left > 0) gap_left--;
          sample_valid <= 1'b0;
        end else begin
          nxt = pending_samples.pop_front();
          sample_value <= nxt.value;
          ends_set     <= nxt.last;
          sample_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 8);
            gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40)
                                                     : $urandom_range(0, 3);
          end
        end
      end
    end
  end

  // receiver: alternating ready and stall stretches, some stalls long enough
  // to back the block up behind its output register
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
    end else begin
      if (result_ready) begin
        hold_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 300)
                                                : $urandom_range(0, 3);
      end else begin
        hold_left = $urandom_range(0, 30);
      end
      result_ready <= !result_ready;
    end
  end

  // monitor: each result against the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction, echoed_value 0x%08h", echoed_value);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("echoed_value", want.value, echoed_value);
        check_field("kept", want.kept, kept);
        check_field("distinct_total", want.total, distinct_total);
        check_field("set_done", want.done, set_done);
        check_field("overflow", want.ovf, overflow);
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // extremes, duplicates of extremes, alternating bit patterns,
    // duplicate as the last element of a set
    add_sample(MOST_NEG, 1'b0);
    add_sample(MOST_POS, 1'b0);
    add_sample('0, 1'b0);
    add_sample(-1, 1'b0);
    add_sample(MOST_NEG, 1'b0);
    add_sample(32'shAAAA_AAAA, 1'b0);
    add_sample(32'sh5555_5555, 1'b0);
    add_sample(-1, 1'b0);
    add_sample(MOST_POS, 1'b1);
    // single-element set; value from the previous set must be new again
    add_sample(MOST_NEG, 1'b1);
    // near-miss values around a repeated one
    add_sample(32'sh0000_0001, 1'b0);
    add_sample(32'sh0000_0001, 1'b0);
    add_sample(32'sh8000_0001, 1'b0);
    add_sample(32'sh7FFF_FFFE, 1'b0);
    add_sample(32'sh0000_0001, 1'b1);
    add_sample('0, 1'b1);

    // hold the sender until the block has fully drained
    while (pending_samples.size() != 0 || sample_valid || expected_results.size() != 0)
      @(posedge clk);

    queued = 0;
    while (queued < 450) small_random_set();
    full_table_set();
    while (queued < 950) small_random_set();
    full_table_set();
    while (queued < 1400) small_random_set();

    while (pending_samples.size() != 0 || sample_valid || expected_results.size() != 0)
      @(posedge clk);
    // allow for any stray result after the last expected one
    repeat (TABLE_DEPTH + 10) @(posedge clk);

    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hard stop in case the block hangs
  initial begin
    #(60_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ stream_duplicate_remover.f @@
src/sdr_pkg.sv
src/sdr_ram.sv
src/sdr_scan.sv
src/stream_duplicate_remover.sv
test/tb_stream_duplicate_remover.sv
